>>> rtl/wlbs_pkg.sv
`timescale 1ns / 1ps
package wlbs_pkg;
  localparam int DataBytesDef = 32;
  localparam int BanksDef = 4;
  localparam int AddrW = 12;
  localparam int StrideW = 11;
  localparam int CfgW = 12;
  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_SCAN = 3'd2;
  localparam logic [2:0] OP_MIGRATE = 3'd3;
  localparam logic [2:0] OP_COMMIT = 3'd4;
  localparam logic [0:0] CFG_BASE = 1'd0;
  localparam logic [0:0] CFG_STRIDE = 1'd1;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0] FlagValid = 8'hFF;
  localparam logic [7:0] FlagClear = 8'h00;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [11:0] write_address;
    logic [7:0]  write_data;
    logic        bank_found;
    logic [1:0]  chosen_bank;
    logic [15:0] generation;
    logic        last;
  } out_item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction
endpackage

>>> rtl/wlbs_if.sv
`timescale 1ns / 1ps
interface wlbs_in_if;
  logic valid;
  logic ready;
  wlbs_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface wlbs_out_if;
  logic valid;
  logic ready;
  wlbs_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/wlbs_ram.sv
`timescale 1ns / 1ps
module wlbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/wlbs_ctrl.sv
`timescale 1ns / 1ps
module wlbs_ctrl #(
  parameter int DataBytes = wlbs_pkg::DataBytesDef,
  parameter int Banks = wlbs_pkg::BanksDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  wlbs_pkg::in_item_t    in_data,
  output logic                  in_ready,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  busy,
  output logic                  op_go,
  output logic                  crc_ph,
  output logic [2:0]            op_code,
  output logic [5:0]            step,
  output logic                  emit,
  output logic                  emit_last
);
  localparam int Steps = 6 + DataBytes + Banks;
  typedef enum logic [1:0] {IDLE, CRC, EMIT, WAIT} st_t;
  st_t st_r;
  logic [5:0] cnt_r;
  logic [2:0] op_r;
  logic [5:0] total;
  logic acc;

  assign acc = in_valid && in_ready;
  assign in_ready = (st_r == IDLE) && !busy;
  assign op_go = acc;
  assign crc_ph = (st_r == CRC);
  assign op_code = op_r;
  assign step = cnt_r;
  assign total = (op_r == wlbs_pkg::OP_MIGRATE) ? 6'(4 + DataBytes + Banks)
                                                : 6'(6 + DataBytes);
  assign emit = (st_r == EMIT) && (!out_valid || out_ready);
  assign emit_last = emit && (cnt_r == total - 6'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= IDLE;
      cnt_r <= '0;
      op_r <= '0;
    end else begin
      case (st_r)
        IDLE: begin
          if (acc && (in_data.opcode == wlbs_pkg::OP_MIGRATE ||
                      in_data.opcode == wlbs_pkg::OP_COMMIT)) begin
            op_r <= in_data.opcode;
            cnt_r <= '0;
            st_r <= CRC;
          end else if (acc && in_data.opcode == wlbs_pkg::OP_SCAN) begin
            st_r <= WAIT;
          end
        end
        CRC: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(DataBytes)) begin
            cnt_r <= '0;
            st_r <= EMIT;
          end
        end
        EMIT: begin
          if (emit) begin
            cnt_r <= cnt_r + 6'd1;
            if (emit_last) begin
              st_r <= WAIT;
            end
          end
        end
        WAIT: begin
          if (!out_valid || out_ready) begin
            st_r <= IDLE;
          end
        end
        default: st_r <= IDLE;
      endcase
    end
  end

  ap_step: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == EMIT |-> cnt_r < 6'(Steps)) else $error("step overrun");
  ap_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != IDLE |-> !in_ready) else $error("ready while busy");
  ap_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit_last |=> st_r == WAIT) else $error("last without finish");
endmodule

>>> rtl/wlbs_dp.sv
`timescale 1ns / 1ps
module wlbs_dp #(
  parameter int DataBytes = wlbs_pkg::DataBytesDef,
  parameter int Banks = wlbs_pkg::BanksDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  op_go,
  input  logic                  crc_ph,
  input  wlbs_pkg::in_item_t    in_data,
  input  logic [2:0]            op_code,
  input  logic [5:0]            step,
  input  logic                  emit,
  input  logic                  emit_last,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [11:0]           cfg_wdata,
  input  logic                  out_ready,
  output logic                  out_valid,
  output wlbs_pkg::out_item_t   out_data,
  output logic                  busy
);
  localparam int IW = 5 + DataBytes;
  localparam int PW = $clog2(IW + 1);
  localparam int DW = (DataBytes > 1) ? $clog2(DataBytes) : 1;
  localparam int BW = $clog2(Banks);
  localparam int SBW = $clog2(Banks + 1);

  logic [11:0] base_r;
  logic [10:0] stride_r;
  logic [BW-1:0] act_b_r;
  logic [15:0] wc_r;
  logic [PW-1:0] spos_r;
  logic [SBW-1:0] sbank_r;
  logic [15:0] icnt_r, icrc_r, rcrc_r, bcnt_r, crc_r;
  logic [7:0] iflag_r;
  logic [BW-1:0] bbank_r;
  logic any_r, done_r;
  logic cand_sel_r, best_sel_r;
  logic ov_r;
  wlbs_pkg::out_item_t od_r;
  logic clr_r;
  logic copy_r;
  logic [DW-1:0] copy_idx_r;
  logic copy_wr_r;
  logic [DW-1:0] copy_w_r;

  logic is_scan, is_load, pay_byte, fin_bank, fin_all, good, take;
  logic [PW-1:0] spos_nxt;
  logic [15:0] rcrc_nxt;
  logic [DW-1:0] pidx;

  assign is_scan = op_go && in_data.opcode == wlbs_pkg::OP_SCAN && !done_r;
  assign is_load = op_go && in_data.opcode == wlbs_pkg::OP_LOAD &&
                   {1'b0, in_data.byte_index} < 6'(DataBytes);
  assign pay_byte = is_scan && spos_r >= PW'(5);
  assign pidx = DW'(spos_r - PW'(5));
  assign spos_nxt = spos_r + PW'(1);
  assign rcrc_nxt = pay_byte ? wlbs_pkg::crc_byte(rcrc_r, in_data.data_byte) : rcrc_r;
  assign fin_bank = is_scan && spos_nxt == PW'(IW);
  assign good = iflag_r == wlbs_pkg::FlagValid && icrc_r == rcrc_nxt;
  assign take = good && (!any_r || icnt_r > bcnt_r);
  assign fin_all = fin_bank && sbank_r == SBW'(Banks - 1);

  // Payload buffers: two candidate/best slots that swap roles, plus the live shadow.
  logic [7:0] buf_rd [2];
  logic [7:0] pay_rd;
  logic [DW-1:0] rd_idx, pay_widx;
  logic pay_we;
  logic [7:0] pay_wd;

  always_comb begin
    rd_idx = '0;
    if (crc_ph) begin
      if (step < 6'(DataBytes)) rd_idx = DW'(step);
    end else if (emit && step >= 6'd4) begin
      rd_idx = DW'(step - 6'd4);
    end else if (step >= 6'd5) begin
      rd_idx = DW'(step - 6'd5);
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_buf
    wlbs_ram #(.Width(8), .Depth(1 << DW)) u_buf (
      .clk(clk), .we(pay_byte && cand_sel_r == 1'(g)), .waddr(pidx),
      .wdata(in_data.data_byte), .raddr(copy_idx_r), .rdata(buf_rd[g]));
  end

  // After a final verdict that found a bank, the best image is copied to the shadow one byte per cycle.
  // After reset the same counter walks the shadow once to clear it.
  assign busy = clr_r || copy_r || copy_wr_r;
  assign pay_we = is_load || copy_wr_r || clr_r;
  assign pay_widx = is_load ? DW'(in_data.byte_index) : (clr_r ? copy_idx_r : copy_w_r);
  assign pay_wd = is_load ? in_data.data_byte : (clr_r ? 8'h00 : buf_rd[best_sel_r]);

  wlbs_ram #(.Width(8), .Depth(1 << DW)) u_pay (
    .clk(clk), .we(pay_we), .waddr(pay_widx), .wdata(pay_wd),
    .raddr(rd_idx), .rdata(pay_rd));

  logic [11:0] bank_off, addr;
  logic [BW-1:0] tgt, nxt_b;
  logic [15:0] gen;
  logic [5:0] e;
  logic [7:0] wd;
  assign nxt_b = (act_b_r == BW'(Banks - 1)) ? '0 : act_b_r + BW'(1);
  assign gen = (op_code == wlbs_pkg::OP_MIGRATE) ? 16'd1 : wc_r + 16'd1;
  assign e = step;
  always_comb begin
    tgt = (op_code == wlbs_pkg::OP_MIGRATE) ? '0 : nxt_b;
    addr = 12'(e);
    wd = pay_rd;
    if (e == 6'd0) wd = gen[15:8];
    else if (e == 6'd1) wd = gen[7:0];
    else if (e == 6'd2) wd = crc_r[15:8];
    else if (e == 6'd3) wd = crc_r[7:0];
    else if (e == 6'd4) wd = wlbs_pkg::FlagValid;
    if (e >= 6'(5 + DataBytes)) begin
      wd = wlbs_pkg::FlagClear;
      addr = 12'd4;
      tgt = (op_code == wlbs_pkg::OP_MIGRATE) ? BW'(e - 6'(4 + DataBytes)) : act_b_r;
    end
  end
  assign bank_off = 12'(23'(tgt) * 23'(stride_r));
  logic [11:0] full_addr;
  assign full_addr = base_r + bank_off + addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 12'd32;
      stride_r <= 11'd64;
      act_b_r <= '0; wc_r <= '0;
      spos_r <= '0; sbank_r <= '0; icnt_r <= '0; icrc_r <= '0; iflag_r <= '0;
      rcrc_r <= wlbs_pkg::CrcInit; bcnt_r <= '0; bbank_r <= '0;
      any_r <= 1'b0; done_r <= 1'b0; cand_sel_r <= 1'b0; best_sel_r <= 1'b1;
      ov_r <= 1'b0; copy_r <= 1'b0; copy_idx_r <= '0; copy_wr_r <= 1'b0;
      copy_w_r <= '0; crc_r <= wlbs_pkg::CrcInit; clr_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wlbs_pkg::CFG_BASE: base_r <= cfg_wdata;
          wlbs_pkg::CFG_STRIDE: stride_r <= cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (ov_r && out_ready) ov_r <= 1'b0;
      copy_wr_r <= copy_r;
      copy_w_r <= copy_idx_r;
      if (copy_r || clr_r) begin
        copy_idx_r <= copy_idx_r + DW'(1);
        if (copy_idx_r == DW'(DataBytes - 1)) begin
          copy_r <= 1'b0;
          clr_r <= 1'b0;
        end
      end
      if (op_go && in_data.opcode == wlbs_pkg::OP_START) begin
        spos_r <= '0; sbank_r <= '0; icnt_r <= '0; icrc_r <= '0; iflag_r <= '0;
        rcrc_r <= wlbs_pkg::CrcInit; bcnt_r <= '0; bbank_r <= '0;
        any_r <= 1'b0; done_r <= 1'b0;
      end
      if (is_scan) begin
        spos_r <= spos_nxt;
        rcrc_r <= rcrc_nxt;
        if (spos_r == PW'(0)) icnt_r[15:8] <= in_data.data_byte;
        if (spos_r == PW'(1)) icnt_r[7:0] <= in_data.data_byte;
        if (spos_r == PW'(2)) icrc_r[15:8] <= in_data.data_byte;
        if (spos_r == PW'(3)) icrc_r[7:0] <= in_data.data_byte;
        if (spos_r == PW'(4)) iflag_r <= in_data.data_byte;
        if (fin_bank) begin
          spos_r <= '0;
          rcrc_r <= wlbs_pkg::CrcInit;
          sbank_r <= sbank_r + SBW'(1);
          if (good) any_r <= 1'b1;
          if (take) begin
            bcnt_r <= icnt_r;
            bbank_r <= BW'(sbank_r);
            best_sel_r <= cand_sel_r;
            cand_sel_r <= best_sel_r;
          end
        end
        if (fin_all) begin
          done_r <= 1'b1;
          ov_r <= 1'b1;
          od_r <= '0;
          od_r.result_kind <= 1'b1;
          od_r.last <= 1'b1;
          if (good || any_r) begin
            od_r.bank_found <= 1'b1;
            act_b_r <= take ? BW'(sbank_r) : bbank_r;
            od_r.chosen_bank <= 2'(take ? BW'(sbank_r) : bbank_r);
            wc_r <= take ? icnt_r : bcnt_r;
            od_r.generation <= take ? icnt_r : bcnt_r;
            copy_r <= 1'b1;
            copy_idx_r <= '0;
          end else begin
            act_b_r <= '0;
            wc_r <= 16'd1;
            od_r.generation <= 16'd1;
          end
        end
      end
      if (op_go && (in_data.opcode == wlbs_pkg::OP_MIGRATE ||
                    in_data.opcode == wlbs_pkg::OP_COMMIT)) begin
        crc_r <= wlbs_pkg::CrcInit;
      end
      if (crc_ph && step != 6'd0) begin
        crc_r <= wlbs_pkg::crc_byte(crc_r, pay_rd);
      end
      if (emit) begin
        ov_r <= 1'b1;
        od_r <= '0;
        od_r.write_address <= full_addr;
        od_r.write_data <= wd;
        od_r.last <= emit_last;
        if (emit_last) begin
          act_b_r <= (op_code == wlbs_pkg::OP_MIGRATE) ? '0 : nxt_b;
          wc_r <= gen;
        end
      end
    end
  end
  assign out_valid = ov_r;
  assign out_data = od_r;

  ap_copy: assert property (@(posedge clk) disable iff (!rst_n)
    copy_r |-> done_r) else $error("copy outside finished scan");
  ap_slots: assert property (@(posedge clk) disable iff (!rst_n)
    cand_sel_r != best_sel_r) else $error("buffer slots collide");
  ap_pos: assert property (@(posedge clk) disable iff (!rst_n)
    spos_r < PW'(IW)) else $error("scan position overrun");
endmodule

>>> rtl/wear_leveled_bank_store_controller.sv
`timescale 1ns / 1ps
// Channel  Dir  Fields
// in_      in   opcode, data_byte, byte_index
// out_     out  result_kind, write_address, write_data, bank_found, chosen_bank,
//               generation, last
// cfg_     in   we, index, wdata
// Load, start and unknown transactions are accepted in IDLE; a scan byte passes through the
// WAIT state, and the final one holds the input until its verdict transaction is taken.
// Commit and migrate run a payload CRC through the shadow RAM read port, then issue
// their write transactions while out_ready is high, then pass through a closing WAIT state.
// After a found verdict the best image is copied into the shadow with the input held.
// Reset is synchronous; after it the shadow is cleared with the input held.
module wear_leveled_bank_store_controller #(
  parameter int DataBytes = wlbs_pkg::DataBytesDef,
  parameter int Banks = wlbs_pkg::BanksDef
) (
  input  logic        clk,
  input  logic        rst_n,
  wlbs_in_if.sink     in_ch,
  wlbs_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);
  logic op_go, crc_ph, emit, emit_last, busy;
  logic [2:0] op_code;
  logic [5:0] step;

  wlbs_ctrl #(.DataBytes(DataBytes), .Banks(Banks)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_data(in_ch.data),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .busy(busy), .op_go(op_go), .crc_ph(crc_ph), .op_code(op_code), .step(step),
    .emit(emit), .emit_last(emit_last));

  wlbs_dp #(.DataBytes(DataBytes), .Banks(Banks)) u_dp (
    .clk(clk), .rst_n(rst_n), .op_go(op_go), .crc_ph(crc_ph), .in_data(in_ch.data),
    .op_code(op_code), .step(step), .emit(emit),
    .emit_last(emit_last), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .out_data(out_ch.data), .busy(busy));
endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import wlbs_pkg::*;

  localparam int NBytes = DataBytesDef;
  localparam int NBanks = BanksDef;
  localparam int ImgLen = 5 + NBytes;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [11:0] cfg_wdata;

  wlbs_in_if in_ch();
  wlbs_out_if out_ch();

  wear_leveled_bank_store_controller dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the controller state.
  bit [7:0] shadow [NBytes];
  bit [7:0] cand_img [NBytes];
  bit [7:0] best_img [NBytes];
  bit [1:0] cur_bank;
  bit [15:0] cur_gen;
  int img_pos;
  int img_bank;
  bit [15:0] img_cnt, img_crc, run_crc, best_cnt;
  bit [7:0] img_flag;
  bit [1:0] best_idx;
  bit found_any, scan_over;
  bit [11:0] base_q;
  bit [10:0] stride_q;

  out_item_t pending_writes [$];
  int errors = 0;
  bit tx_idle, rx_stall;
  int hold_left = 0;
  int stall_pct = 72;

  function automatic bit [15:0] crc16_update(bit [15:0] c, bit [7:0] b);
    bit fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return c;
  endfunction

  function automatic bit [11:0] bank_addr(int bank, int off);
    int a;
    a = base_q + bank * stride_q + off;
    return a[11:0];
  endfunction

  function automatic void push_write(bit [11:0] addr, bit [7:0] val);
    out_item_t r;
    r = '0;
    r.write_address = addr;
    r.write_data = val;
    pending_writes.push_back(r);
  endfunction

  function automatic void mark_last();
    out_item_t r;
    r = pending_writes[$];
    r.last = 1'b1;
    pending_writes[pending_writes.size() - 1] = r;
  endfunction

  function automatic void save_image(int bank, bit [15:0] cnt);
    bit [15:0] c;
    c = CrcInit;
    for (int i = 0; i < NBytes; i++) c = crc16_update(c, shadow[i]);
    push_write(bank_addr(bank, 0), cnt[15:8]);
    push_write(bank_addr(bank, 1), cnt[7:0]);
    push_write(bank_addr(bank, 2), c[15:8]);
    push_write(bank_addr(bank, 3), c[7:0]);
    push_write(bank_addr(bank, 4), FlagValid);
    for (int i = 0; i < NBytes; i++) push_write(bank_addr(bank, 5 + i), shadow[i]);
  endfunction

  function automatic void restart_scan();
    img_pos = 0;
    img_bank = 0;
    img_cnt = 0;
    img_crc = 0;
    img_flag = 0;
    run_crc = CrcInit;
    best_cnt = 0;
    best_idx = 0;
    found_any = 0;
    scan_over = 0;
  endfunction

  function automatic void take_scan_byte(bit [7:0] b);
    out_item_t r;
    if (scan_over) return;
    case (img_pos)
      0: img_cnt[15:8] = b;
      1: img_cnt[7:0] = b;
      2: img_crc[15:8] = b;
      3: img_crc[7:0] = b;
      4: img_flag = b;
      default: begin
        cand_img[img_pos - 5] = b;
        run_crc = crc16_update(run_crc, b);
      end
    endcase
    img_pos++;
    if (img_pos < ImgLen) return;
    if (img_flag == FlagValid && img_crc == run_crc) begin
      if (!found_any || img_cnt > best_cnt) begin
        best_cnt = img_cnt;
        best_idx = img_bank[1:0];
        best_img = cand_img;
      end
      found_any = 1;
    end
    img_pos = 0;
    run_crc = CrcInit;
    img_bank++;
    if (img_bank < NBanks) return;
    scan_over = 1;
    if (found_any) begin
      cur_bank = best_idx;
      cur_gen = best_cnt;
      shadow = best_img;
    end else begin
      cur_bank = 0;
      cur_gen = 16'd1;
    end
    r = '0;
    r.result_kind = 1'b1;
    r.bank_found = found_any;
    r.chosen_bank = cur_bank;
    r.generation = cur_gen;
    r.last = 1'b1;
    pending_writes.push_back(r);
  endfunction

  function automatic void predict_item(in_item_t it);
    bit [1:0] nxt;
    case (it.opcode)
      OP_LOAD: shadow[it.byte_index] = it.data_byte;
      OP_START: restart_scan();
      OP_SCAN: take_scan_byte(it.data_byte);
      OP_MIGRATE: begin
        save_image(0, 16'd1);
        for (int i = 1; i < NBanks; i++) push_write(bank_addr(i, 4), FlagClear);
        cur_bank = 0;
        cur_gen = 16'd1;
        mark_last();
      end
      OP_COMMIT: begin
        nxt = cur_bank + 2'd1;
        save_image(nxt, cur_gen + 16'd1);
        push_write(bank_addr(cur_bank, 4), FlagClear);
        cur_bank = nxt;
        cur_gen = cur_gen + 16'd1;
        mark_last();
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    while (tx_idle && $urandom_range(0, 99) < stall_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = it;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(it);
    @(negedge clk);
  endtask

  task automatic send_op(logic [2:0] op, logic [7:0] d, logic [4:0] idx);
    in_item_t it;
    it.opcode = op;
    it.data_byte = d;
    it.byte_index = idx;
    send_item(it);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [11:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_BASE) base_q = val;
    else stride_q = val[10:0];
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    wait (pending_writes.size() == 0);
    repeat (80) @(negedge clk);
  endtask

  task automatic scan_pass();
    bit [7:0] img [ImgLen];
    bit [15:0] c, cnt;
    int pick;
    send_op(OP_START, 8'($urandom), 5'($urandom));
    for (int b = 0; b < NBanks; b++) begin
      pick = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0: cnt = 16'hFFFF;
        1: cnt = 16'h0000;
        2: cnt = 16'd7;
        default: cnt = 16'($urandom);
      endcase
      c = CrcInit;
      for (int i = 0; i < NBytes; i++) begin
        img[5 + i] = 8'($urandom);
        c = crc16_update(c, img[5 + i]);
      end
      img[0] = cnt[15:8];
      img[1] = cnt[7:0];
      img[2] = c[15:8];
      img[3] = (pick == 8) ? c[7:0] ^ 8'h01 : c[7:0];
      img[4] = (pick == 9) ? 8'($urandom_range(0, 254)) : FlagValid;
      for (int i = 0; i < ImgLen; i++) send_op(OP_SCAN, img[i], 5'($urandom));
      if ($urandom_range(0, 9) == 0) send_op(OP_COMMIT, 8'($urandom), 5'($urandom));
    end
    if ($urandom_range(0, 1) == 0) send_op(OP_SCAN, 8'($urandom), 5'($urandom));
  endtask

  task automatic random_ops(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50) send_op(OP_LOAD, 8'($urandom), 5'($urandom));
      else if (r < 62) send_op(OP_COMMIT, 8'($urandom), 5'($urandom));
      else if (r < 68) send_op(OP_MIGRATE, 8'($urandom), 5'($urandom));
      else if (r < 76) send_op(3'($urandom_range(5, 7)), 8'($urandom), 5'($urandom));
      else if (r < 84) send_op(OP_SCAN, 8'($urandom), 5'($urandom));
      else if (r < 88) send_op(OP_START, 8'($urandom), 5'($urandom));
      else send_op(OP_LOAD, 8'($urandom), 5'($urandom));
    end
  endtask

  typedef struct {
    in_item_t   it;
    bit         known;
    out_item_t  final_write;
  } vector_t;

  vector_t vectors [] = '{
    '{'{OP_LOAD, 8'hFF, 5'd0}, 0, '0},
    '{'{OP_LOAD, 8'h00, 5'd31}, 0, '0},
    '{'{OP_LOAD, 8'hA5, 5'd15}, 0, '0},
    '{'{OP_COMMIT, 8'h00, 5'd0}, 1, '{1'b0, 12'd36, 8'h00, 1'b0, 2'd0, 16'd0, 1'b1}},
    '{'{OP_MIGRATE, 8'hFF, 5'd31}, 1, '{1'b0, 12'd228, 8'h00, 1'b0, 2'd0, 16'd0, 1'b1}},
    '{'{3'd7, 8'hFF, 5'd31}, 0, '0},
    '{'{3'd5, 8'h55, 5'd10}, 0, '0},
    '{'{3'd6, 8'hAA, 5'd21}, 0, '0},
    '{'{OP_COMMIT, 8'hFF, 5'd31}, 1, '{1'b0, 12'd36, 8'h00, 1'b0, 2'd0, 16'd0, 1'b1}},
    '{'{OP_COMMIT, 8'h12, 5'd3}, 0, '0},
    '{'{OP_SCAN, 8'hFF, 5'd0}, 0, '0},
    '{'{OP_START, 8'h00, 5'd0}, 0, '0},
    '{'{OP_COMMIT, 8'h00, 5'd0}, 0, '0},
    '{'{OP_COMMIT, 8'h00, 5'd0}, 0, '0},
    '{'{OP_MIGRATE, 8'h00, 5'd0}, 0, '0}
  };

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = !(rx_stall && $urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected result transaction %p", out_ch.data);
        errors++;
      end else begin
        want = pending_writes.pop_front();
        if (out_ch.data.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind,
                 out_ch.data.result_kind);
          errors++;
        end
        if (out_ch.data.write_address !== want.write_address) begin
          $error("write_address: expected %0d, got %0d", want.write_address,
                 out_ch.data.write_address);
          errors++;
        end
        if (out_ch.data.write_data !== want.write_data) begin
          $error("write_data: expected %0h, got %0h", want.write_data,
                 out_ch.data.write_data);
          errors++;
        end
        if (out_ch.data.bank_found !== want.bank_found) begin
          $error("bank_found: expected %0d, got %0d", want.bank_found,
                 out_ch.data.bank_found);
          errors++;
        end
        if (out_ch.data.chosen_bank !== want.chosen_bank) begin
          $error("chosen_bank: expected %0d, got %0d", want.chosen_bank,
                 out_ch.data.chosen_bank);
          errors++;
        end
        if (out_ch.data.generation !== want.generation) begin
          $error("generation: expected %0d, got %0d", want.generation,
                 out_ch.data.generation);
          errors++;
        end
        if (out_ch.data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.data.last);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    tx_idle = 0;
    rx_stall = 0;
    shadow = '{default: 8'h00};
    cand_img = '{default: 8'h00};
    best_img = '{default: 8'h00};
    cur_bank = 0;
    cur_gen = 0;
    base_q = 12'd32;
    stride_q = 11'd64;
    restart_scan();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (vectors[v]) begin
      send_item(vectors[v].it);
      if (vectors[v].known && pending_writes[$] != vectors[v].final_write) begin
        $error("final write: expected %p, got %p", vectors[v].final_write,
               pending_writes[$]);
        errors++;
      end
    end
    hold_left = 400;
    repeat (3) send_op(OP_COMMIT, 8'($urandom), 5'($urandom));
    settle();

    for (int ph = 1; ph < 5; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_BASE, 12'd0);
          write_reg(CFG_STRIDE, 12'd1024);
          tx_idle = 1;
          rx_stall = 0;
          stall_pct = 72;
        end
        2: begin
          write_reg(CFG_BASE, 12'd4095);
          write_reg(CFG_STRIDE, 12'd6);
          tx_idle = 0;
          rx_stall = 1;
          stall_pct = 72;
        end
        3: begin
          write_reg(CFG_BASE, 12'($urandom));
          write_reg(CFG_STRIDE, 12'($urandom_range(6, 1024)));
          tx_idle = 1;
          rx_stall = 1;
          stall_pct = 12;
        end
        default: begin
          write_reg(CFG_BASE, 12'd32);
          write_reg(CFG_STRIDE, 12'd37);
          tx_idle = 0;
          rx_stall = 0;
        end
      endcase
      if (ph == 2) scan_pass();
      random_ops(8);
      settle();
    end

    in_ch.valid = 1'b0;
    wait (pending_writes.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_writes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
